// File: rtl/core/brs_pkg.sv
package brs_pkg;

   // defaults for the top-level parameters
   localparam int MAX_WIDTH_DEF  = 128;
   localparam int MAX_HEIGHT_DEF = 128;
   localparam int FRAC_BITS_DEF  = 8;

   // field widths
   localparam int DIM_W     = 8;
   localparam int ORG_W     = 15;
   localparam int STEP_W    = 16;
   localparam int DIST_W    = 16;
   localparam int PIX_IDX_W = 14;
   localparam int CHAN_W    = 8;
   localparam int PIX_W     = 3 * CHAN_W;

   // ray arithmetic
   localparam int STEP_FRAC = 14;
   localparam int PROD_W    = STEP_W + DIST_W + 1;
   localparam int POS_W     = PROD_W - STEP_FRAC + 1;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_X     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Y     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_X       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_Y       = 3'd5;

   localparam logic [DIM_W-1:0]  RST_IMAGE_WIDTH  = 8'd128;
   localparam logic [DIM_W-1:0]  RST_IMAGE_HEIGHT = 8'd128;
   localparam logic [ORG_W-1:0]  RST_ORIGIN_X     = 15'd0;
   localparam logic [ORG_W-1:0]  RST_ORIGIN_Y     = 15'd0;
   localparam logic [STEP_W-1:0] RST_STEP_X       = 16'h4000;
   localparam logic [STEP_W-1:0] RST_STEP_Y       = 16'h0000;

   localparam logic MODE_WRITE  = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   typedef logic [PIX_W-1:0] pix_type;

   typedef struct packed {
      logic                 mode;
      logic [PIX_IDX_W-1:0] pixel_index;
      logic [CHAN_W-1:0]    in_red;
      logic [CHAN_W-1:0]    in_green;
      logic [CHAN_W-1:0]    in_blue;
      logic [DIST_W-1:0]    distance;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              out_of_range;
   } rsp_type;

endpackage

// File: rtl/core/bilinear_ray_sampler_core.sv
// Bilinear ray sampler with a built-in RGB frame store.
// Request channel (req_valid/req_stall/req_data): mode 0 stores one pixel at
// pixel_index and gives no response; mode 1 samples the frame at
// origin + step * distance and gives exactly one response.
// Response channel (rsp_valid/rsp_stall/rsp_data): interpolated red, green,
// blue and an out_of_range flag (color forced to black when the 2x2 patch
// leaves the frame or the frame size registers are out of range).
// Registers on the csr_ port set frame size, ray origin and ray step; write
// them only while no transaction is in flight.
// Throughput: one transaction per cycle while a stalled response does not
// freeze the pipeline. A sample passes 7 register stages (ray multiply,
// position add, row multiply and weights, address add, frame read, channel
// multiply, sum) before it shows on rsp_valid. The four neighbors come from
// two copies of the frame store, each read at two addresses per cycle.
// Writes and samples retire in order, so a sample sees every earlier write.
// Reset clears the pipeline and loads the register defaults; frame contents
// are undefined until written, and no clearing pass runs.
// A stall on a valid response freezes the whole pipeline and raises req_stall
// in the same cycle; nothing is dropped or repeated.
module bilinear_ray_sampler_core #(
   parameter int MAX_WIDTH  = brs_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = brs_pkg::MAX_HEIGHT_DEF,
   parameter int FRAC_BITS  = brs_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  brs_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output brs_pkg::rsp_type                 rsp_data,
   input  logic                             csr_wr_en,
   input  logic [brs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [brs_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int WIDX_W      = ((ADDR_W > brs_pkg::PIX_IDX_W) ?
                                 ADDR_W : brs_pkg::PIX_IDX_W) + 1;
   localparam int POS_W       = brs_pkg::POS_W;
   localparam int COORD_W     = POS_W - 1 - FRAC_BITS;
   localparam int CMP_W       = (COORD_W + 1 > 12) ? COORD_W + 1 : 12;
   localparam int FW_W        = FRAC_BITS + 1;
   localparam int W_W         = 2 * FRAC_BITS + 1;
   localparam int PRD_W       = W_W + brs_pkg::CHAN_W;
   localparam int SUM_W       = PRD_W + 2;
   localparam int CW          = brs_pkg::CHAN_W;

   // configuration registers
   logic [brs_pkg::DIM_W-1:0]         csr_width_ff;
   logic [brs_pkg::DIM_W-1:0]         csr_height_ff;
   logic [brs_pkg::ORG_W-1:0]         csr_origin_x_ff;
   logic [brs_pkg::ORG_W-1:0]         csr_origin_y_ff;
   logic signed [brs_pkg::STEP_W-1:0] csr_step_x_ff;
   logic signed [brs_pkg::STEP_W-1:0] csr_step_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_width_ff    <= brs_pkg::RST_IMAGE_WIDTH;
         csr_height_ff   <= brs_pkg::RST_IMAGE_HEIGHT;
         csr_origin_x_ff <= brs_pkg::RST_ORIGIN_X;
         csr_origin_y_ff <= brs_pkg::RST_ORIGIN_Y;
         csr_step_x_ff   <= brs_pkg::RST_STEP_X;
         csr_step_y_ff   <= brs_pkg::RST_STEP_Y;
      end else if (csr_wr_en) begin
         case (csr_index)
            brs_pkg::REG_IMAGE_WIDTH:  csr_width_ff    <= csr_wdata[brs_pkg::DIM_W-1:0];
            brs_pkg::REG_IMAGE_HEIGHT: csr_height_ff   <= csr_wdata[brs_pkg::DIM_W-1:0];
            brs_pkg::REG_ORIGIN_X:     csr_origin_x_ff <= csr_wdata[brs_pkg::ORG_W-1:0];
            brs_pkg::REG_ORIGIN_Y:     csr_origin_y_ff <= csr_wdata[brs_pkg::ORG_W-1:0];
            brs_pkg::REG_STEP_X:       csr_step_x_ff   <= csr_wdata[brs_pkg::STEP_W-1:0];
            brs_pkg::REG_STEP_Y:       csr_step_y_ff   <= csr_wdata[brs_pkg::STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // the whole pipeline moves together; hold everything while the output waits
   logic pipe_adv;
   logic rsp_vld_ff;

   assign pipe_adv  = ~rsp_vld_ff | ~rsp_stall;
   assign req_stall = ~pipe_adv;

   // stage 1: ray multiply
   logic                              s1_vld_ff;
   brs_pkg::req_type                  s1_item_ff;
   logic signed [brs_pkg::PROD_W-1:0] s1_prod_x_ff, s1_prod_x_in;
   logic signed [brs_pkg::PROD_W-1:0] s1_prod_y_ff, s1_prod_y_in;

   assign s1_prod_x_in = csr_step_x_ff * $signed({1'b0, req_data.distance});
   assign s1_prod_y_in = csr_step_y_ff * $signed({1'b0, req_data.distance});

   // stage 2: position, delta floored by an arithmetic shift
   logic                    s2_vld_ff;
   brs_pkg::req_type        s2_item_ff;
   logic signed [POS_W-1:0] s2_pos_x_ff, s2_pos_x_in;
   logic signed [POS_W-1:0] s2_pos_y_ff, s2_pos_y_in;

   assign s2_pos_x_in = POS_W'(signed'({1'b0, csr_origin_x_ff})) +
                        POS_W'(signed'(s1_prod_x_ff[brs_pkg::PROD_W-1:brs_pkg::STEP_FRAC]));
   assign s2_pos_y_in = POS_W'(signed'({1'b0, csr_origin_y_ff})) +
                        POS_W'(signed'(s1_prod_y_ff[brs_pkg::PROD_W-1:brs_pkg::STEP_FRAC]));

   // stage 3: range check, row offset, weights, write address
   logic [COORD_W-1:0]   s3_xi_c, s3_yi_c;
   logic [FRAC_BITS-1:0] s3_xf_c, s3_yf_c;
   logic [FW_W-1:0]      s3_ixf_c, s3_iyf_c;
   logic [WIDX_W-1:0]    s3_widx_c;
   logic                 s3_size_ok_c;

   logic                 s3_vld_ff;
   logic                 s3_mode_ff;
   logic                 s3_wr_ok_ff, s3_wr_ok_in;
   logic [ADDR_W-1:0]    s3_waddr_ff, s3_waddr_in;
   brs_pkg::pix_type     s3_pix_ff;
   logic                 s3_oor_ff, s3_oor_in;
   logic [ADDR_W-1:0]    s3_row_ff, s3_row_in;
   logic [ADDR_W-1:0]    s3_xi_ff;
   logic [W_W-1:0]       s3_w_ff [4];
   logic [W_W-1:0]       s3_w_in [4];

   always_comb begin
      s3_xi_c  = s2_pos_x_ff[POS_W-2:FRAC_BITS];
      s3_yi_c  = s2_pos_y_ff[POS_W-2:FRAC_BITS];
      s3_xf_c  = s2_pos_x_ff[FRAC_BITS-1:0];
      s3_yf_c  = s2_pos_y_ff[FRAC_BITS-1:0];
      s3_ixf_c = (FW_W'(1) << FRAC_BITS) - FW_W'(s3_xf_c);
      s3_iyf_c = (FW_W'(1) << FRAC_BITS) - FW_W'(s3_yf_c);

      s3_size_ok_c = (csr_width_ff >= brs_pkg::DIM_W'(2)) &&
                     (CMP_W'(csr_width_ff) <= CMP_W'(MAX_WIDTH)) &&
                     (csr_height_ff >= brs_pkg::DIM_W'(2)) &&
                     (CMP_W'(csr_height_ff) <= CMP_W'(MAX_HEIGHT));

      s3_oor_in = ~s3_size_ok_c ||
                  s2_pos_x_ff[POS_W-1] || s2_pos_y_ff[POS_W-1] ||
                  (CMP_W'(s3_xi_c) + CMP_W'(1) >= CMP_W'(csr_width_ff)) ||
                  (CMP_W'(s3_yi_c) + CMP_W'(1) >= CMP_W'(csr_height_ff));

      s3_row_in = ADDR_W'(s3_yi_c) * ADDR_W'(csr_width_ff);

      s3_w_in[0] = W_W'(s3_ixf_c) * W_W'(s3_iyf_c);
      s3_w_in[1] = W_W'(s3_xf_c)  * W_W'(s3_iyf_c);
      s3_w_in[2] = W_W'(s3_ixf_c) * W_W'(s3_yf_c);
      s3_w_in[3] = W_W'(s3_xf_c)  * W_W'(s3_yf_c);

      s3_widx_c   = WIDX_W'(s2_item_ff.pixel_index);
      s3_wr_ok_in = s3_widx_c < WIDX_W'(STORE_DEPTH);
      s3_waddr_in = s3_widx_c[ADDR_W-1:0];
   end

   // stage 4: neighbor addresses (top-left slot carries the write address)
   logic                 s4_vld_ff;
   logic                 s4_mode_ff;
   logic                 s4_wr_ok_ff;
   brs_pkg::pix_type     s4_pix_ff;
   logic                 s4_oor_ff;
   logic [ADDR_W-1:0]    s4_a_ff [4];
   logic [ADDR_W-1:0]    s4_a_in [4];
   logic [W_W-1:0]       s4_w_ff [4];
   logic [ADDR_W-1:0]    s4_base_c;
   logic [ADDR_W-1:0]    s4_below_c;

   always_comb begin
      s4_base_c  = s3_row_ff + s3_xi_ff;
      s4_below_c = s4_base_c + ADDR_W'(csr_width_ff);
      s4_a_in[0] = (s3_mode_ff == brs_pkg::MODE_WRITE) ? s3_waddr_ff : s4_base_c;
      s4_a_in[1] = s4_base_c + ADDR_W'(1);
      s4_a_in[2] = s4_below_c;
      s4_a_in[3] = s4_below_c + ADDR_W'(1);
   end

   // stage 5: frame store, two copies with two read ports each
   brs_pkg::pix_type mem_a [STORE_DEPTH];
   brs_pkg::pix_type mem_b [STORE_DEPTH];

   logic                 s5_vld_ff;
   logic                 s5_oor_ff;
   brs_pkg::pix_type     s5_q_ff [4];
   logic [W_W-1:0]       s5_w_ff [4];

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         if (s4_vld_ff && s4_mode_ff == brs_pkg::MODE_WRITE && s4_wr_ok_ff) begin
            mem_a[s4_a_ff[0]] <= s4_pix_ff;
            mem_b[s4_a_ff[0]] <= s4_pix_ff;
         end
         s5_q_ff[0] <= mem_a[s4_a_ff[0]];
         s5_q_ff[1] <= mem_a[s4_a_ff[1]];
         s5_q_ff[2] <= mem_b[s4_a_ff[2]];
         s5_q_ff[3] <= mem_b[s4_a_ff[3]];
      end
   end

   // stage 6: per-channel weighted products
   logic             s6_vld_ff;
   logic             s6_oor_ff;
   logic [PRD_W-1:0] s6_prd_ff [3][4];
   logic [PRD_W-1:0] s6_prd_in [3][4];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         for (int n = 0; n < 4; n++) begin
            s6_prd_in[c][n] = PRD_W'(s5_q_ff[n][brs_pkg::PIX_W-1-CW*c -: CW]) *
                              PRD_W'(s5_w_ff[n]);
         end
      end
   end

   // stage 7: sum, truncate, output register
   brs_pkg::rsp_type rsp_ff, rsp_in;

   always_comb begin
      logic [SUM_W-1:0] sum;
      logic [CW-1:0]    chan [3];
      for (int c = 0; c < 3; c++) begin
         sum = SUM_W'(s6_prd_ff[c][0]) + SUM_W'(s6_prd_ff[c][1]) +
               SUM_W'(s6_prd_ff[c][2]) + SUM_W'(s6_prd_ff[c][3]);
         chan[c] = s6_oor_ff ? '0 : sum[2*FRAC_BITS +: CW];
      end
      rsp_in.red          = chan[0];
      rsp_in.green        = chan[1];
      rsp_in.blue         = chan[2];
      rsp_in.out_of_range = s6_oor_ff;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         s5_vld_ff  <= 1'b0;
         s6_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (pipe_adv) begin
         s1_vld_ff  <= req_valid;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         s4_vld_ff  <= s3_vld_ff;
         // drop write transactions once the store has taken them
         s5_vld_ff  <= s4_vld_ff && (s4_mode_ff == brs_pkg::MODE_SAMPLE);
         s6_vld_ff  <= s5_vld_ff;
         rsp_vld_ff <= s6_vld_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         s1_item_ff   <= req_data;
         s1_prod_x_ff <= s1_prod_x_in;
         s1_prod_y_ff <= s1_prod_y_in;

         s2_item_ff   <= s1_item_ff;
         s2_pos_x_ff  <= s2_pos_x_in;
         s2_pos_y_ff  <= s2_pos_y_in;

         s3_mode_ff   <= s2_item_ff.mode;
         s3_wr_ok_ff  <= s3_wr_ok_in;
         s3_waddr_ff  <= s3_waddr_in;
         s3_pix_ff    <= {s2_item_ff.in_red, s2_item_ff.in_green, s2_item_ff.in_blue};
         s3_oor_ff    <= s3_oor_in;
         s3_row_ff    <= s3_row_in;
         s3_xi_ff     <= ADDR_W'(s3_xi_c);
         s3_w_ff      <= s3_w_in;

         s4_mode_ff   <= s3_mode_ff;
         s4_wr_ok_ff  <= s3_wr_ok_ff;
         s4_pix_ff    <= s3_pix_ff;
         s4_oor_ff    <= s3_oor_ff;
         s4_a_ff      <= s4_a_in;
         s4_w_ff      <= s3_w_ff;

         s5_oor_ff    <= s4_oor_ff;
         s5_w_ff      <= s4_w_ff;

         s6_oor_ff    <= s5_oor_ff;
         s6_prd_ff    <= s6_prd_in;

         rsp_ff       <= rsp_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: rtl/core/brs_chk.sv
module brs_chk (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input brs_pkg::rsp_type               rsp_data
);

   // a stalled response holds its transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // an out-of-frame sample is black
   a_oor_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_of_range |->
         rsp_data.red == '0 && rsp_data.green == '0 && rsp_data.blue == '0)
      else $error("out-of-range response carries color");

   // the request side backs up only behind a stalled response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled response");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind bilinear_ray_sampler_core brs_chk u_brs_chk (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// File: tb/sv/tb_bilinear_ray_sampler_core.sv
module tb_bilinear_ray_sampler_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH  = brs_pkg::MAX_WIDTH_DEF * brs_pkg::MAX_HEIGHT_DEF;
   localparam int SETTLE_CYCLES = 12;
   localparam int QUIET_LIMIT  = 2000;
   localparam int FRAC         = brs_pkg::FRAC_BITS_DEF;
   localparam int CHAN_W       = brs_pkg::CHAN_W;

   // Tracks the frame store and ray registers, predicts one color per sample
   class sample_scoreboard;
      brs_pkg::pix_type frame[STORE_DEPTH];
      bit               written[STORE_DEPTH];
      int unsigned      width, height;
      int               origin_x, origin_y, step_x, step_y;
      brs_pkg::rsp_type pending_colors[$];
      int               errors, writes, samples, blanks, settings;

      function new();
         width    = brs_pkg::RST_IMAGE_WIDTH;
         height   = brs_pkg::RST_IMAGE_HEIGHT;
         origin_x = brs_pkg::RST_ORIGIN_X;
         origin_y = brs_pkg::RST_ORIGIN_Y;
         step_x   = $signed(brs_pkg::RST_STEP_X);
         step_y   = $signed(brs_pkg::RST_STEP_Y);
      endfunction

      function void set_reg(logic [brs_pkg::CSR_IDX_W-1:0] idx,
                            logic [brs_pkg::CSR_DATA_W-1:0] v);
         case (idx)
            brs_pkg::REG_IMAGE_WIDTH:  width    = v[brs_pkg::DIM_W-1:0];
            brs_pkg::REG_IMAGE_HEIGHT: height   = v[brs_pkg::DIM_W-1:0];
            brs_pkg::REG_ORIGIN_X:     origin_x = v[brs_pkg::ORG_W-1:0];
            brs_pkg::REG_ORIGIN_Y:     origin_y = v[brs_pkg::ORG_W-1:0];
            brs_pkg::REG_STEP_X:       step_x   = $signed(v[brs_pkg::STEP_W-1:0]);
            brs_pkg::REG_STEP_Y:       step_y   = $signed(v[brs_pkg::STEP_W-1:0]);
            default: ;
         endcase
      endfunction

      // Top-left address, fractions of the 2x2 patch; 0 if off frame or size illegal
      function bit patch_origin(input logic [brs_pkg::DIST_W-1:0] reach, output int base,
                                output int fx, output int fy);
         longint px, py, xi, yi;
         base = 0;
         fx   = 0;
         fy   = 0;
         if (width < 2 || width > brs_pkg::MAX_WIDTH_DEF ||
             height < 2 || height > brs_pkg::MAX_HEIGHT_DEF)
            return 0;
         px = longint'(origin_x) +
              ((longint'(step_x) * longint'(reach)) >>> brs_pkg::STEP_FRAC);
         py = longint'(origin_y) +
              ((longint'(step_y) * longint'(reach)) >>> brs_pkg::STEP_FRAC);
         if (px < 0 || py < 0)
            return 0;
         xi = px >> FRAC;
         yi = py >> FRAC;
         if (xi + 1 >= width || yi + 1 >= height)
            return 0;
         fx   = int'(px & ((1 << FRAC) - 1));
         fy   = int'(py & ((1 << FRAC) - 1));
         base = int'(yi * width + xi);
         return 1;
      endfunction

      function void note_request(brs_pkg::req_type r);
         brs_pkg::rsp_type  want;
         int                base, fx, fy, one;
         brs_pkg::pix_type  q[4];
         longint            wt[4], acc;
         logic [CHAN_W-1:0] chan[3];
         if (r.mode == brs_pkg::MODE_WRITE) begin
            frame[r.pixel_index]   = {r.in_red, r.in_green, r.in_blue};
            written[r.pixel_index] = 1'b1;
            writes++;
            return;
         end
         samples++;
         want = '0;
         want.out_of_range = 1'b1;
         if (patch_origin(r.distance, base, fx, fy)) begin
            one   = 1 << FRAC;
            q[0]  = frame[base];
            q[1]  = frame[base + 1];
            q[2]  = frame[base + int'(width)];
            q[3]  = frame[base + int'(width) + 1];
            wt[0] = (one - fx) * (one - fy);
            wt[1] = fx * (one - fy);
            wt[2] = (one - fx) * fy;
            wt[3] = fx * fy;
            for (int c = 0; c < 3; c++) begin
               acc = 0;
               for (int k = 0; k < 4; k++)
                  acc += longint'(q[k][brs_pkg::PIX_W - CHAN_W * (c + 1) +: CHAN_W]) *
                         wt[k];
               chan[c] = CHAN_W'(acc >> (2 * FRAC));
            end
            want = {chan[0], chan[1], chan[2], 1'b0};
         end else begin
            blanks++;
         end
         pending_colors.push_back(want);
      endfunction

      function void check_color(brs_pkg::rsp_type got);
         brs_pkg::rsp_type want;
         if (pending_colors.size() == 0) begin
            $error("response with no sample pending: %h", got);
            errors++;
            return;
         end
         want = pending_colors.pop_front();
         if (got.red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, got.red);
            errors++;
         end
         if (got.green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, got.green);
            errors++;
         end
         if (got.blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, got.blue);
            errors++;
         end
         if (got.out_of_range !== want.out_of_range) begin
            $error("out_of_range: expected %0d, got %0d", want.out_of_range,
                   got.out_of_range);
            errors++;
         end
      endfunction
   endclass

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_stall;
   brs_pkg::req_type               req_data;
   logic                           rsp_valid;
   logic                           rsp_stall;
   brs_pkg::rsp_type               rsp_data;
   logic                           csr_wr_en;
   logic [brs_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [brs_pkg::CSR_DATA_W-1:0] csr_wdata;

   sample_scoreboard board = new();
   bit req_idle_on;
   bit rsp_idle_on;
   int quiet_cycles;

   bilinear_ray_sampler_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // Receiver: check each accepted transaction, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         board.check_color(rsp_data);
      rsp_stall <= !reset && rsp_idle_on && ($urandom_range(99) < 13);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic [CHAN_W-1:0] rand_chan();
      return CHAN_W'($urandom_range(255));
   endfunction

   task automatic send_req(brs_pkg::req_type r);
      while (req_idle_on && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.note_request(r);
   endtask

   task automatic pixel_write(int idx, logic [CHAN_W-1:0] red, logic [CHAN_W-1:0] green,
                              logic [CHAN_W-1:0] blue);
      brs_pkg::req_type r;
      r             = '0;
      r.mode        = brs_pkg::MODE_WRITE;
      r.pixel_index = brs_pkg::PIX_IDX_W'(idx);
      r.in_red      = red;
      r.in_green    = green;
      r.in_blue     = blue;
      r.distance    = brs_pkg::DIST_W'($urandom_range(16'hFFFF));
      send_req(r);
   endtask

   // Fill any neighbor not yet written, then sample
   task automatic send_sample(logic [brs_pkg::DIST_W-1:0] reach);
      brs_pkg::req_type r;
      int               base, fx, fy;
      int               addr[4];
      if (board.patch_origin(reach, base, fx, fy)) begin
         addr = '{base, base + 1, base + int'(board.width), base + int'(board.width) + 1};
         foreach (addr[k])
            if (!board.written[addr[k]])
               pixel_write(addr[k], rand_chan(), rand_chan(), rand_chan());
      end
      r             = '0;
      r.mode        = brs_pkg::MODE_SAMPLE;
      r.pixel_index = brs_pkg::PIX_IDX_W'($urandom_range(STORE_DEPTH - 1));
      r.in_red      = rand_chan();
      r.in_green    = rand_chan();
      r.in_blue     = rand_chan();
      r.distance    = reach;
      send_req(r);
   endtask

   // Hold the sender until every pending sample is back, then let writes retire
   task automatic drain();
      req_valid  <= 1'b0;
      rsp_idle_on = 1'b0;
      while (board.pending_colors.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [brs_pkg::CSR_IDX_W-1:0] idx,
                            logic [brs_pkg::CSR_DATA_W-1:0] v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      board.set_reg(idx, v);
   endtask

   task automatic set_ray(int w, int h, int ox, int oy, int sx, int sy);
      drain();
      csr_write(brs_pkg::REG_IMAGE_WIDTH, brs_pkg::CSR_DATA_W'(w));
      csr_write(brs_pkg::REG_IMAGE_HEIGHT, brs_pkg::CSR_DATA_W'(h));
      csr_write(brs_pkg::REG_ORIGIN_X, brs_pkg::CSR_DATA_W'(ox));
      csr_write(brs_pkg::REG_ORIGIN_Y, brs_pkg::CSR_DATA_W'(oy));
      csr_write(brs_pkg::REG_STEP_X, brs_pkg::CSR_DATA_W'(sx));
      csr_write(brs_pkg::REG_STEP_Y, brs_pkg::CSR_DATA_W'(sy));
      csr_wr_en <= 1'b0;
      board.settings++;
   endtask

   task automatic run_mix(int n, int span, bit calm);
      int area;
      int pick;
      req_idle_on = !calm;
      rsp_idle_on = !calm;
      area = int'(board.width * board.height);
      if (area < 1 || area > STORE_DEPTH)
         area = STORE_DEPTH;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(99);
         if (pick < 55)
            send_sample(brs_pkg::DIST_W'($urandom_range(span)));
         else if (pick < 67)
            send_sample(brs_pkg::DIST_W'($urandom_range(16'hFFFF)));
         else if (pick < 92)
            pixel_write($urandom_range(area - 1), rand_chan(), rand_chan(), rand_chan());
         else
            pixel_write($urandom_range(STORE_DEPTH - 1), rand_chan(), rand_chan(),
                        rand_chan());
      end
   endtask

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_stall   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset registers: 128x128 frame, ray along x from the corner
      pixel_write(0, 8'hFF, 8'h00, 8'hFF);
      pixel_write(STORE_DEPTH - 1, 8'h00, 8'hFF, 8'h00);
      send_sample(16'h0000);
      send_sample(16'h0180);
      send_sample(16'h7EFF);
      send_sample(16'h7F00);
      send_sample(16'hFFFF);

      // Steepest negative step from the far corner: in frame, then negative
      set_ray(8, 8, 15'h7FFF, 16'h0100, 16'h8000, 16'h0000);
      rsp_idle_on = 1'b1;
      send_sample(16'h3C80);
      send_sample(16'h4000);
      send_sample(16'hFFFF);

      // Frame sizes outside the legal range answer black
      set_ray(1, 128, 0, 0, 16'h4000, 0);
      send_sample(16'h0000);
      set_ray(129, 2, 0, 0, 16'h4000, 0);
      send_sample(16'h0000);
      set_ray(8, 0, 0, 0, 16'h4000, 0);
      send_sample(16'h0000);
      set_ray(2, 255, 0, 0, 16'h4000, 0);
      send_sample(16'h0000);

      set_ray(16, 12, 16'h0200, 16'h0380, 16'h4000, 16'h1000);
      run_mix(45, 12 * 256, 1'b0);
      set_ray(2, 2, 0, 0, 16'h2000, 16'h2000);
      run_mix(35, 2 * 256, 1'b0);
      set_ray(128, 128, 15'h7FFF, 16'h0A00, 16'h8000, 16'h7FFF);
      run_mix(45, 58 * 256, 1'b0);
      set_ray(40, 100, 0, 15'h7FFF, 16'h0800, 16'hF000);
      run_mix(45, 16'hFFFF, 1'b0);
      set_ray(200, 50, 16'h0100, 16'h0100, 16'h4000, 16'h4000);
      run_mix(10, 16'hFFFF, 1'b0);
      set_ray(0, 1, 0, 0, 16'h4000, 0);
      run_mix(10, 16'hFFFF, 1'b0);
      set_ray(64, 64, 16'h0100, 16'h0100, 16'h1555, 16'h0E00);
      run_mix(80, 100 * 256, 1'b1);
      set_ray(10, 10, 16'h0580, 16'h0740, 0, 0);
      run_mix(15, 16'hFFFF, 1'b0);

      drain();
      $display("Run covered %0d pixel writes and %0d samples (%0d outside the frame)",
               board.writes, board.samples, board.blanks);
      $display("over %0d ray and frame settings after the reset defaults.", board.settings);
      if (board.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
